// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define AFR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afr assertion failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define AFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afr assertion failed");

`endif

// ----- rtl/afr_pkg.sv -----
// types and constants of the addressed frame receiver
package afr_pkg;

    localparam int unsigned BUFFER_BYTES_DEF = 256;
    localparam int unsigned ADDR_BYTES_DEF   = 1;
    localparam int unsigned LEN_BYTES_DEF    = 2;
    localparam int unsigned HEADER_BYTES_DEF = 6;

    localparam logic [7:0] SYNC_BYTE  = 8'h16;
    localparam logic [7:0] END_BYTE   = 8'h0d;
    localparam logic [7:0] BCAST_BYTE = 8'hff;

    localparam int unsigned      EXP_W    = 17;
    localparam logic [EXP_W-1:0] EXP_IDLE = 17'h1ffff;

    typedef enum logic [1:0] {
        CMD_RECV    = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_READ    = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } item_t;

    typedef struct packed {
        logic       frame_ready;
        logic [8:0] byte_count;
        logic [7:0] read_data;
    } result_t;

    typedef logic [15:0] station_addr_t;

endpackage

// ----- rtl/afr_stream_if.sv -----
// valid/ready channel carrying one request payload
interface afr_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/addressed_frame_receiver.sv -----
// Addressed frame receiver: collects serial bytes into a frame buffer memory, checks sync,
// address and length, and locks a frame terminated by 0x0d at its expected size until a
// release request. Takes one request per clock cycle with no gaps unless the result output
// stalls; each request gives one result through the frame buffer's registered read port
// and the output register. The buffer has one write port used by receive requests and
// one read port used by read requests, so the rate is never limited by it.
// A byte written by one request is visible to a read request in the very next cycle.
module addressed_frame_receiver
    import afr_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int unsigned ADDR_BYTES   = ADDR_BYTES_DEF,
    parameter int unsigned LEN_BYTES    = LEN_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    afr_stream_if.sink    item,
    afr_stream_if.source  result,
    afr_stream_if.sink    cfg
);

    `include "assert_macros.svh"

    localparam int unsigned AW = $clog2(BUFFER_BYTES);
    localparam int unsigned CW = $clog2(BUFFER_BYTES + 2);
    localparam int unsigned RW = (CW > 8) ? CW : 8;

    localparam logic [CW-1:0]    BUF_LIM      = CW'(BUFFER_BYTES);
    localparam logic [CW-1:0]    HDR_N        = CW'(HEADER_BYTES);
    localparam logic [CW-1:0]    ADDR_N       = CW'(2 + ADDR_BYTES);
    localparam logic [CW-1:0]    SYNC1_N      = CW'(1);
    localparam logic [CW-1:0]    SYNC2_N      = CW'(2);
    localparam logic [EXP_W-1:0] HDR_PLUS_END = EXP_W'(HEADER_BYTES + 2);
    localparam logic [EXP_W-1:0] BUF_LIM_EXP  = EXP_W'(BUFFER_BYTES);
    localparam logic [RW-1:0]    BUF_LIM_RD   = RW'(BUFFER_BYTES);

    // frame buffer
    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] mem_rdata_reg;

    // frame state
    station_addr_t    station_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [EXP_W-1:0] exp_reg, exp_next;
    logic             locked_reg, locked_next;
    logic [7:0]       prev_byte_reg;

    // pipeline
    logic          s1_valid_reg;
    logic          s1_frame_reg;
    logic [CW-1:0] s1_count_reg;
    logic          s1_is_read_reg;
    logic          out_valid_reg;
    result_t       out_data_reg;

    logic             accept;
    logic             s1_adv;
    logic             wr_en;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             rd_in_range;
    logic [CW-1:0]    n;
    logic [EXP_W-1:0] len_val;
    logic [EXP_W-1:0] exp_calc;
    logic             addr_ok;
    logic [7:0]       rx;

    assign rx = item.data.rx_byte;

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_adv;
    assign accept     = item.valid && item.ready;

    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    assign rd_in_range = RW'(item.data.read_index) < BUF_LIM_RD;
    assign rd_addr     = AW'(item.data.read_index);
    assign rd_en       = accept && (item.data.command == CMD_READ) && rd_in_range;

    assign n        = count_reg + CW'(1);
    assign len_val  = (LEN_BYTES == 1) ? EXP_W'(rx) : EXP_W'({prev_byte_reg, rx});
    assign exp_calc = len_val + HDR_PLUS_END;
    // address bytes arrive big-endian, the last one is the current byte
    assign addr_ok  = (ADDR_BYTES == 1)
                    ? ((rx == station_reg[7:0]) || (rx == BCAST_BYTE))
                    : ((prev_byte_reg == station_reg[15:8] && rx == station_reg[7:0]) ||
                       (prev_byte_reg == BCAST_BYTE && rx == BCAST_BYTE));

    always_comb
    begin
        count_next  = count_reg;
        exp_next    = exp_reg;
        locked_next = locked_reg;
        wr_en       = 1'b0;
        if (accept)
        begin
            case (item.data.command)
                CMD_RECV:
                begin
                    if (!locked_reg)
                    begin
                        wr_en      = count_reg < BUF_LIM;
                        count_next = n;
                        if (n > HDR_N)
                        begin
                            if (rx == END_BYTE && EXP_W'(n) == exp_reg)
                            begin
                                locked_next = 1'b1;
                            end
                            else if (EXP_W'(n) > exp_reg || n > BUF_LIM)
                            begin
                                count_next = '0;
                                exp_next   = EXP_IDLE;
                            end
                        end
                        else if (n == HDR_N)
                        begin
                            exp_next = exp_calc;
                            if (exp_calc > BUF_LIM_EXP)
                            begin
                                count_next = '0;
                            end
                        end
                        else if (n == ADDR_N)
                        begin
                            if (!addr_ok)
                            begin
                                count_next = '0;
                            end
                        end
                        else if (n == SYNC1_N || n == SYNC2_N)
                        begin
                            if (rx != SYNC_BYTE)
                            begin
                                count_next = '0;
                            end
                        end
                    end
                end
                CMD_RELEASE:
                begin
                    locked_next = 1'b0;
                    count_next  = '0;
                    exp_next    = EXP_IDLE;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= rx;
        end
        if (rd_en)
        begin
            mem_rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg   <= '0;
            count_reg     <= '0;
            exp_reg       <= EXP_IDLE;
            locked_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                station_reg <= cfg.data;
            end
            count_reg  <= count_next;
            exp_reg    <= exp_next;
            locked_reg <= locked_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prev_byte_reg <= rx;
        end
        if (accept)
        begin
            s1_frame_reg   <= locked_next;
            s1_count_reg   <= count_next;
            s1_is_read_reg <= rd_en;
        end
        if (s1_adv)
        begin
            out_data_reg.frame_ready <= s1_frame_reg;
            out_data_reg.byte_count  <= 9'(s1_count_reg);
            out_data_reg.read_data   <= s1_is_read_reg ? mem_rdata_reg : 8'h00;
        end
    end

    `AFR_ASSERT_NEXT(a_lock_holds, locked_reg && !(accept && item.data.command == CMD_RELEASE), locked_reg && $stable(count_reg))
    `AFR_ASSERT_NEXT(a_release_clears, accept && item.data.command == CMD_RELEASE, !locked_reg && count_reg == '0 && exp_reg == EXP_IDLE)
    `AFR_ASSERT_NEXT(a_s1_stall_holds, s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_count_reg) && $stable(s1_is_read_reg))
    `AFR_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= BUF_LIM)

endmodule
